>>> src/dq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

    localparam int DEPTH     = 16;
    localparam int DATA_W    = 32;
    localparam int MODE_W    = 3;
    localparam int WORD_W    = 32;
    localparam int ENTRIES_W = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_BACK  = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_POP_BACK   = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_CLEAR      = 3'd4
    } mode_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [WORD_W-1:0] data_in;
    } op_t;

    typedef struct packed {
        logic [WORD_W-1:0]    front_word;
        logic [WORD_W-1:0]    back_word;
        logic [ENTRIES_W-1:0] entries;
        logic                 is_empty;
        logic                 op_error;
    } res_t;

    // Per-cycle commands broadcast along the row of cells
    typedef struct packed {
        logic shift_in;   // every word moves one cell away from the head
        logic shift_out;  // every word moves one cell towards the head
        logic load_back;  // cell after the back marker takes the new word
        logic mark_home;  // back marker returns to the head cell
        logic mark_fwd;   // back marker moves away from the head
        logic mark_back;  // back marker moves towards the head
    } cell_ctl_t;

endpackage

`default_nettype wire

>>> src/dq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module dq_cell #(
    parameter int DATA_W = dq_pkg::DATA_W
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dq_pkg::cell_ctl_t ctl,
    input  wire logic              head,
    input  wire logic [DATA_W-1:0] din,
    input  wire logic [DATA_W-1:0] prev_word,
    input  wire logic              prev_mark,
    input  wire logic [DATA_W-1:0] next_word,
    input  wire logic              next_mark,
    output logic      [DATA_W-1:0] word,
    output logic                   mark
);

    logic [DATA_W-1:0] word_reg;
    logic [DATA_W-1:0] word_next;
    logic              mark_reg;
    logic              mark_next;

    always_comb
    begin
        if (ctl.shift_in)
        begin
            word_next = prev_word;
        end
        else if (ctl.shift_out)
        begin
            word_next = next_word;
        end
        else if (ctl.load_back && prev_mark)
        begin
            word_next = din;
        end
        else
        begin
            word_next = word_reg;
        end
    end

    always_comb
    begin
        if (ctl.mark_home)
        begin
            mark_next = head;
        end
        else if (ctl.mark_fwd)
        begin
            mark_next = prev_mark;
        end
        else if (ctl.mark_back)
        begin
            mark_next = next_mark;
        end
        else
        begin
            mark_next = mark_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= head;
        end
        else
        begin
            mark_reg <= mark_next;
        end
    end

    assign word = word_reg;
    assign mark = mark_reg;

endmodule

`default_nettype wire

>>> src/double_ended_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue of DEPTH words. One operation (push back, push front,
// pop back, pop front, clear) is taken per clock; busy is never raised, so start
// may be held high every cycle. The result appears with done one cycle after the
// item is taken and stays for that one cycle only: the receiver must take it then.
// Words sit in a row of cells with the front always in the head cell; push front
// and pop front shift the whole row by one cell, push back writes the cell after
// a one-hot back marker that walks along the row. Back word is picked out of the
// marked cell. Push on full or pop on empty leaves the store as it is and sets
// op_error; front_word and back_word read zero while the queue is empty.
module double_ended_queue #(
    parameter int DEPTH  = dq_pkg::DEPTH,
    parameter int DATA_W = dq_pkg::DATA_W
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire dq_pkg::op_t op,
    output logic             busy,
    output logic             done,
    output dq_pkg::res_t     res
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              done_reg;
    logic              err_reg;
    logic              err_next;

    logic              accept;
    logic              empty;
    logic              full;
    logic              push_front;
    logic              push_back;
    logic              pop_front;
    logic              pop_back;
    logic              clear;
    logic [DATA_W-1:0] din;

    dq_pkg::cell_ctl_t ctl;

    logic [DATA_W-1:0] words [DEPTH];
    logic [DEPTH-1:0]  marks;
    logic [DATA_W-1:0] back_sel;

    assign accept = start && !busy;
    assign busy   = 1'b0;
    assign empty  = (cnt_reg == '0);
    assign full   = (cnt_reg == CNT_W'(DEPTH));
    assign din    = DATA_W'(op.data_in);

    always_comb
    begin
        push_front = 1'b0;
        push_back  = 1'b0;
        pop_front  = 1'b0;
        pop_back   = 1'b0;
        clear      = 1'b0;
        err_next   = 1'b0;
        if (accept)
        begin
            case (op.mode)
                dq_pkg::MODE_PUSH_BACK:
                begin
                    push_back = !full;
                    err_next  = full;
                end
                dq_pkg::MODE_PUSH_FRONT:
                begin
                    push_front = !full;
                    err_next   = full;
                end
                dq_pkg::MODE_POP_BACK:
                begin
                    pop_back = !empty;
                    err_next = empty;
                end
                dq_pkg::MODE_POP_FRONT:
                begin
                    pop_front = !empty;
                    err_next  = empty;
                end
                dq_pkg::MODE_CLEAR:
                begin
                    clear = 1'b1;
                end
                default:
                begin
                    err_next = 1'b0;
                end
            endcase
        end
    end

    // A push into an empty queue behaves as a push at the front.
    always_comb
    begin
        ctl.shift_in  = push_front || (push_back && empty);
        ctl.shift_out = pop_front;
        ctl.load_back = push_back && !empty;
        ctl.mark_home = clear || ((push_front || push_back) && empty);
        ctl.mark_fwd  = (push_front || push_back) && !empty;
        ctl.mark_back = (pop_front || pop_back) && (cnt_reg > CNT_W'(1));
    end

    always_comb
    begin
        if (clear)
        begin
            cnt_next = '0;
        end
        else if (push_front || push_back)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop_front || pop_back)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] prev_word;
        logic              prev_mark;
        logic [DATA_W-1:0] next_word;
        logic              next_mark;

        if (i == 0)
        begin : g_head
            assign prev_word = din;
            assign prev_mark = 1'b0;
        end
        else
        begin : g_body
            assign prev_word = words[i-1];
            assign prev_mark = marks[i-1];
        end

        // Last cell refills with its own word; that slot is beyond the count anyway.
        if (i == DEPTH - 1)
        begin : g_tail
            assign next_word = words[i];
            assign next_mark = 1'b0;
        end
        else
        begin : g_mid
            assign next_word = words[i+1];
            assign next_mark = marks[i+1];
        end

        dq_cell #(
            .DATA_W (DATA_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .head      ((i == 0) ? 1'b1 : 1'b0),
            .din       (din),
            .prev_word (prev_word),
            .prev_mark (prev_mark),
            .next_word (next_word),
            .next_mark (next_mark),
            .word      (words[i]),
            .mark      (marks[i])
        );
    end

    always_comb
    begin
        back_sel = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_sel = back_sel | (marks[i] ? words[i] : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            err_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= accept;
            err_reg  <= err_next;
        end
    end

    assign done           = done_reg;
    assign res.front_word = empty ? '0 : dq_pkg::WORD_W'(words[0]);
    assign res.back_word  = empty ? '0 : dq_pkg::WORD_W'(back_sel);
    assign res.entries    = dq_pkg::ENTRIES_W'(cnt_reg);
    assign res.is_empty   = empty;
    assign res.op_error   = err_reg;

    a_mark_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(marks))
        else $error("back marker not one-hot");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("count beyond depth");

    a_err_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && err_reg |-> cnt_reg == $past(cnt_reg))
        else $error("rejected item changed the count");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        accept && op.mode == dq_pkg::MODE_CLEAR |=> empty && !err_reg && marks[0])
        else $error("clear did not empty the queue");

endmodule

`default_nettype wire
